>>> design/rrts_pkg.sv
// rrts_pkg: shared types and constants for the round-robin time slice scheduler
// holds queue sizing, status and request codes and the queue entry layout
// no dependencies
`timescale 1ns / 1ps

package rrts_pkg;

   // ready queue sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int ID_W      = 8;
   localparam int TIME_W    = 16;
   localparam int QUANTUM_W = 8;
   localparam int CLOCK_W   = 32;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(2);
   localparam logic [CLOCK_W-1:0]   CLOCK_MAX     = '1;

   // request codes
   typedef enum logic [0:0] {
      REQ_ENQUEUE = 1'b0,
      REQ_SLICE   = 1'b1
   } req_code_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_RAN      = 2'd2,
      STATUS_IDLE     = 2'd3
   } status_type;

   // one ready queue entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] remaining;
   } entry_type;

endpackage

>>> design/rrts_if.sv
// rrts_req_if / rrts_rsp_if: valid/ready channels of the scheduler
// request word carries an enqueue or slice request, response word the result
// depends on rrts_pkg
`timescale 1ns / 1ps

interface rrts_req_if
   import rrts_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [ID_W-1:0]   proc_id;
   logic [TIME_W-1:0] burst_time;

   modport source (output valid, output req_type, output proc_id, output burst_time,
                   input ready);
   modport sink   (input valid, input req_type, input proc_id, input burst_time,
                   output ready);
endinterface

interface rrts_rsp_if
   import rrts_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [ID_W-1:0]      ran_id;
   logic [QUANTUM_W-1:0] slice_len;
   logic [TIME_W-1:0]    remaining_after;
   logic                 finished;
   logic [CLOCK_W-1:0]   clock_now;

   modport source (output valid, output status, output ran_id, output slice_len,
                   output remaining_after, output finished, output clock_now,
                   input ready);
   modport sink   (input valid, input status, input ran_id, input slice_len,
                   input remaining_after, input finished, input clock_now,
                   output ready);
endinterface

>>> design/round_robin_time_slice_scheduler_unit.sv
// round_robin_time_slice_scheduler_unit: fixed-quantum round-robin scheduler
// depends on rrts_pkg and the channel interfaces in rrts_if.sv
//
// Usage:
//   req_ch (sink) takes one request word per item: req_type 0 puts proc_id and
//   burst_time at the tail of the ready queue, req_type 1 runs the head process
//   for min(remaining, quantum) ticks and requeues it unless it finished.
//   rsp_ch (source) returns exactly one response word per request, in order.
//   csr_wr_en / csr_wr_data write the quantum register; write only while idle.
// Timing:
//   A request passes an accept step and an execute step: the accept cycle reads
//   the queue head from the entry memory, the execute step forms the response
//   and writes back the tail entry. The response is registered and goes valid
//   after the execute step; no new request is accepted until the previous one
//   has left the execute step.
//   A new request may be accepted while the previous response is still
//   waiting; it then holds in the execute step until the response is taken.
// Reset:
//   Synchronous, active high. Clears the queue pointers, occupancy, system
//   clock and handshake state and sets the quantum to 2. Entry memory is not
//   cleared; occupancy guarantees unwritten entries are never read.
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_unit
   import rrts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   rrts_req_if.sink             req_ch,
   rrts_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [QUANTUM_W-1:0] csr_wr_data
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // control state
   state_type            state_ff,   state_in;
   logic [PTR_W-1:0]     head_ff,    head_in;
   logic [PTR_W-1:0]     tail_ff,    tail_in;
   logic [OCC_W-1:0]     occ_ff,     occ_in;
   logic [CLOCK_W-1:0]   sysclk_ff,  sysclk_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // latched request word
   logic                 req_slice_ff;
   logic [ID_W-1:0]      req_id_ff;
   logic [TIME_W-1:0]    req_burst_ff;

   // response payload registers
   status_type           status_ff,    status_in;
   logic [ID_W-1:0]      ran_id_ff,    ran_id_in;
   logic [QUANTUM_W-1:0] slice_len_ff, slice_len_in;
   logic [TIME_W-1:0]    rem_after_ff, rem_after_in;
   logic                 finished_ff,  finished_in;
   logic [CLOCK_W-1:0]   clock_now_ff, clock_now_in;

   // entry memory
   entry_type            mem [QUEUE_DEPTH];
   entry_type            mem_rd_ff;
   logic                 mem_wr_en;
   entry_type            mem_wr_data;

   logic                 req_accept;
   logic                 exec_fire;
   logic                 q_full;
   logic                 q_empty;
   logic [QUANTUM_W-1:0] len;
   logic [TIME_W-1:0]    rem_left;
   logic [CLOCK_W:0]     clk_sum;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign exec_fire    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign q_full  = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign q_empty = (occ_ff == '0);

   // slice arithmetic on the head entry
   assign len      = (mem_rd_ff.remaining < TIME_W'(quantum_ff))
                     ? mem_rd_ff.remaining[QUANTUM_W-1:0] : quantum_ff;
   assign rem_left = mem_rd_ff.remaining - TIME_W'(len);
   assign clk_sum  = {1'b0, sysclk_ff} + (CLOCK_W + 1)'(len);

   // next-state and response logic
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      sysclk_in    = sysclk_ff;
      quantum_in   = csr_wr_en ? csr_wr_data : quantum_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      status_in    = status_ff;
      ran_id_in    = ran_id_ff;
      slice_len_in = slice_len_ff;
      rem_after_in = rem_after_ff;
      finished_in  = finished_ff;
      clock_now_in = clock_now_ff;
      mem_wr_en    = 1'b0;
      mem_wr_data  = '{id: req_id_ff, remaining: req_burst_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               ran_id_in    = '0;
               slice_len_in = '0;
               rem_after_in = '0;
               finished_in  = 1'b0;
               clock_now_in = '0;
               if (!req_slice_ff) begin
                  // enqueue at tail unless full
                  if (q_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in = STATUS_ENQUEUED;
                     mem_wr_en = 1'b1;
                     tail_in   = next_slot(tail_ff);
                     occ_in    = occ_ff + OCC_W'(1);
                  end
               end else if (q_empty) begin
                  status_in = STATUS_IDLE;
               end else begin
                  // run head, requeue if work remains
                  status_in    = STATUS_RAN;
                  head_in      = next_slot(head_ff);
                  sysclk_in    = clk_sum[CLOCK_W] ? CLOCK_MAX : clk_sum[CLOCK_W-1:0];
                  ran_id_in    = mem_rd_ff.id;
                  slice_len_in = len;
                  rem_after_in = rem_left;
                  finished_in  = (rem_left == '0);
                  clock_now_in = sysclk_in;
                  if (rem_left == '0) begin
                     occ_in = occ_ff - OCC_W'(1);
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = '{id: mem_rd_ff.id, remaining: rem_left};
                     tail_in     = next_slot(tail_ff);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         sysclk_ff    <= '0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         sysclk_ff    <= sysclk_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff    <= status_in;
      ran_id_ff    <= ran_id_in;
      slice_len_ff <= slice_len_in;
      rem_after_ff <= rem_after_in;
      finished_ff  <= finished_in;
      clock_now_ff <= clock_now_in;
      if (req_accept) begin
         req_slice_ff <= (req_ch.req_type == REQ_SLICE);
         req_id_ff    <= req_ch.proc_id;
         req_burst_ff <= req_ch.burst_time;
      end
   end

   // entry memory: head read on accept, tail write on execute
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[tail_ff] <= mem_wr_data;
      end
      if (req_accept) begin
         mem_rd_ff <= mem[head_ff];
      end
   end

   // response channel
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.ran_id          = ran_id_ff;
   assign rsp_ch.slice_len       = slice_len_ff;
   assign rsp_ch.remaining_after = rem_after_ff;
   assign rsp_ch.finished        = finished_ff;
   assign rsp_ch.clock_now       = clock_now_ff;

   // occupancy never exceeds the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   // empty or full queue has head and tail on the same slot
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (q_empty || q_full) |-> (head_ff == tail_ff))
      else $error("queue pointers inconsistent with occupancy");

   // an accepted request moves to execute on the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   // a finished slice reports no remaining time
   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && finished_ff) |-> (status_ff == STATUS_RAN && rem_after_ff == '0))
      else $error("finished slice with remaining time");

   // non-slice responses carry zero payload
   a_idle_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_RAN) |-> (ran_id_ff == '0 && clock_now_ff == '0))
      else $error("non-slice response with payload");

endmodule

>>> tb/sv/tb.sv
// tb: self-checking bench for the round-robin time slice scheduler unit
// drives request words from a queue, predicts every response and checks it in order
// depends on rrts_pkg, rrts_req_if, rrts_rsp_if and round_robin_time_slice_scheduler_unit
`timescale 1ns / 1ps

module tb;
   import rrts_pkg::*;

   localparam int LONG_STALL     = 400;
   localparam int WATCHDOG_LIMIT = 2000;

   // one request word waiting to be offered
   typedef struct packed {
      req_code_type      kind;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] burst;
   } sched_req_type;

   // one predicted response word
   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      ran_id;
      logic [QUANTUM_W-1:0] slice_len;
      logic [TIME_W-1:0]    remaining_after;
      logic                 finished;
      logic [CLOCK_W-1:0]   clock_now;
   } sched_result_type;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [QUANTUM_W-1:0] csr_wr_data = '0;

   rrts_req_if req_bus ();
   rrts_rsp_if rsp_bus ();

   round_robin_time_slice_scheduler_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus.sink),
      .rsp_ch      (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the scheduler state
   logic [ID_W-1:0]      ready_ids   [QUEUE_DEPTH];
   logic [TIME_W-1:0]    ready_times [QUEUE_DEPTH];
   int                   ready_head  = 0;
   int                   ready_tail  = 0;
   int                   ready_count = 0;
   logic [CLOCK_W-1:0]   sim_clock   = '0;
   logic [QUANTUM_W-1:0] quantum_q   = QUANTUM_RESET;

   sched_req_type    pending_requests[$];
   sched_result_type expected_results[$];

   int   req_idle_max = 15;
   int   rsp_idle_max = 15;
   int   req_gap      = 0;
   int   rsp_wait     = 0;
   int   stall_left   = 0;
   logic stall_arm    = 1'b0;
   logic stall_done   = 1'b0;
   int   quiet_cycles = 0;
   int   error_count  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // put a process at the tail of the shadow queue
   function automatic void append_process(input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] remaining);
      ready_ids[ready_tail]   = id;
      ready_times[ready_tail] = remaining;
      ready_tail              = (ready_tail + 1) % QUEUE_DEPTH;
      ready_count++;
   endfunction

   // work out the response of one request and advance the shadow state
   function automatic sched_result_type schedule_request(input logic kind,
                                                         input logic [ID_W-1:0] id,
                                                         input logic [TIME_W-1:0] burst);
      sched_result_type  r;
      logic [ID_W-1:0]   head_id;
      logic [TIME_W-1:0] head_rem;
      logic [TIME_W-1:0] len;
      logic [CLOCK_W:0]  sum;
      r = '0;
      if (kind == REQ_ENQUEUE) begin
         if (ready_count >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            append_process(id, burst);
            r.status = STATUS_ENQUEUED;
         end
      end else if (ready_count == 0) begin
         r.status = STATUS_IDLE;
      end else begin
         head_id     = ready_ids[ready_head];
         head_rem    = ready_times[ready_head];
         len         = (head_rem < TIME_W'(quantum_q)) ? head_rem : TIME_W'(quantum_q);
         ready_head  = (ready_head + 1) % QUEUE_DEPTH;
         ready_count--;
         head_rem    = head_rem - len;
         // system clock saturates instead of wrapping
         sum         = {1'b0, sim_clock} + (CLOCK_W + 1)'(len);
         sim_clock   = sum[CLOCK_W] ? CLOCK_MAX : sum[CLOCK_W-1:0];
         if (head_rem != '0)
            append_process(head_id, head_rem);
         r.status          = STATUS_RAN;
         r.ran_id          = head_id;
         r.slice_len       = len[QUANTUM_W-1:0];
         r.remaining_after = head_rem;
         r.finished        = (head_rem == '0);
         r.clock_now       = sim_clock;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // request driver: offers queued words with a random gap after each one
   always @(posedge clock) begin : drive_requests
      sched_req_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(schedule_request(req_bus.req_type, req_bus.proc_id,
                                                        req_bus.burst_time));
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_bus.valid <= 1'b0;
               req_gap       <= req_gap - 1;
            end else if (pending_requests.size() > 0) begin
               next_req           = pending_requests.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= next_req.kind;
               req_bus.proc_id    <= next_req.id;
               req_bus.burst_time <= next_req.burst;
               req_gap            <= $urandom_range(0, req_idle_max);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each word against the oldest prediction and paces ready
   always @(posedge clock) begin : check_responses
      sched_result_type want;
      int               w;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait      <= 0;
         stall_left    <= 0;
         stall_done    <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("response word with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               check_field("ran_id", 32'(want.ran_id), 32'(rsp_bus.ran_id));
               check_field("slice_len", 32'(want.slice_len), 32'(rsp_bus.slice_len));
               check_field("remaining_after", 32'(want.remaining_after),
                           32'(rsp_bus.remaining_after));
               check_field("finished", 32'(want.finished), 32'(rsp_bus.finished));
               check_field("clock_now", want.clock_now, rsp_bus.clock_now);
            end
         end
         // one long hold-off so the block backs up into its input
         if (stall_arm && !stall_done) begin
            stall_done    <= 1'b1;
            stall_left    <= LONG_STALL;
            rsp_wait      <= 0;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= (stall_left == 1);
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            w             = $urandom_range(0, rsp_idle_max);
            rsp_wait      <= w;
            rsp_bus.ready <= (w == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait      <= rsp_wait - 1;
            rsp_bus.ready <= (rsp_wait == 1);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(input req_code_type kind, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] burst);
      sched_req_type r;
      r.kind  = kind;
      r.id    = id;
      r.burst = burst;
      pending_requests.push_back(r);
   endtask

   // random mix of slices and enqueues; slices carry noise in the ignored fields
   task automatic queue_random(input int count, input int slice_pct, input int burst_cap,
                               input int big_pct);
      logic [TIME_W-1:0] burst;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < slice_pct) begin
            queue_request(REQ_SLICE, ID_W'($urandom), TIME_W'($urandom));
         end else begin
            if ($urandom_range(0, 99) < big_pct)
               burst = TIME_W'($urandom);
            else
               burst = TIME_W'($urandom_range(0, burst_cap));
            queue_request(REQ_ENQUEUE, ID_W'($urandom), burst);
         end
      end
   endtask

   task automatic wait_until_drained();
      do
         @(posedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
      wait_until_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= q;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      quantum_q   = q;
   endtask

   // stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, zero service time, fill to full, wrap around
      queue_request(REQ_SLICE, '1, '1);
      queue_request(REQ_ENQUEUE, 8'h00, 16'h0000);
      queue_request(REQ_SLICE, 8'h00, 16'h0000);
      queue_request(REQ_ENQUEUE, 8'hFF, 16'hFFFF);
      for (int k = 1; k < QUEUE_DEPTH; k++)
         queue_request(REQ_ENQUEUE, ID_W'(k), TIME_W'((k % 3) + 1));
      queue_request(REQ_ENQUEUE, 8'h5A, 16'h0007);
      queue_request(REQ_SLICE, 8'h00, 16'h0000);
      queue_request(REQ_SLICE, 8'hA5, 16'h5A5A);

      // largest quantum
      set_quantum(8'hFF);
      queue_request(REQ_SLICE, 8'h00, 16'h0000);
      queue_request(REQ_SLICE, 8'h00, 16'h0000);

      // zero quantum: unfinished processes only rotate
      set_quantum(8'h00);
      queue_request(REQ_ENQUEUE, 8'h33, 16'h0000);
      queue_request(REQ_SLICE, 8'h00, 16'h0000);
      queue_request(REQ_SLICE, 8'h00, 16'h0000);

      // quantum of one, balanced load
      set_quantum(8'h01);
      queue_random(300, 50, 8, 0);

      // largest quantum, enqueue heavy so the queue runs full
      set_quantum(8'hFF);
      queue_random(300, 35, 1000, 0);

      // mid quantum, slice heavy so the queue runs empty; sender never idles
      set_quantum(QUANTUM_W'($urandom_range(3, 254)));
      req_idle_max <= 0;
      queue_random(300, 70, 600, 0);

      // no idling on either side
      set_quantum(QUANTUM_RESET);
      rsp_idle_max <= 0;
      queue_random(300, 50, 12, 0);

      // largest quantum with full range bursts and one long receiver hold-off
      set_quantum(8'hFF);
      req_idle_max <= 15;
      rsp_idle_max <= 15;
      queue_random(500, 55, 2000, 5);
      wait (pending_requests.size() <= 450);
      @(posedge clock);
      stall_arm <= 1'b1;

      wait_until_drained();
      repeat (6) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d predicted responses never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
